>>> rtl/header_field_line_matcher_macros.svh
// ----------------------------------------------------------------------------
// Header field line matcher: assertion macros
// Concurrent check shorthands clocked on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef HEADER_FIELD_LINE_MATCHER_MACROS_SVH
`define HEADER_FIELD_LINE_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("header field line matcher check failed");

// Consequent must hold in the cycle after the antecedent.
`define HFLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("header field line matcher check failed");

`endif

>>> rtl/hflm_pkg.sv
// ----------------------------------------------------------------------------
// hflm_pkg
// Types and constants shared by the header field line matcher modules.
// ----------------------------------------------------------------------------
package hflm_pkg;

  localparam int NAME_MAX_BYTES = 16;
  localparam int NAME_SLOTS     = 16;
  localparam int POS_BITS       = 16;
  localparam int OFFSET_BITS    = 16;
  localparam int LEN_BITS       = 5;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;

  localparam logic [CFG_IDX_BITS-1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NAME_LEN  = 2'd2;

  typedef struct packed {
    logic       terminator;
    logic [7:0] text_byte;
  } in_beat_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] value_offset;
    logic                   overflow;
  } out_beat_t;

  typedef struct packed {
    logic [NAME_SLOTS-1:0][7:0] name;
    logic [LEN_BITS-1:0]        active_len;
  } match_cfg_t;

endpackage

>>> rtl/hflm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hflm_cfg_regs
// Field name registers and the clamped active name length.
// ----------------------------------------------------------------------------
module hflm_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [hflm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hflm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output hflm_pkg::match_cfg_t                 match_cfg
);

  logic [hflm_pkg::CFG_DATA_BITS-1:0] name_low_r;
  logic [hflm_pkg::CFG_DATA_BITS-1:0] name_high_r;
  logic [hflm_pkg::LEN_BITS-1:0]      name_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r  <= '0;
      name_high_r <= '0;
      name_len_r  <= hflm_pkg::LEN_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hflm_pkg::REG_NAME_LOW:  name_low_r  <= cfg_wdata;
        hflm_pkg::REG_NAME_HIGH: name_high_r <= cfg_wdata;
        hflm_pkg::REG_NAME_LEN:  name_len_r  <= cfg_wdata[hflm_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero length behaves as one byte; anything past the slot count is capped.
  always_comb begin
    match_cfg.name = {name_high_r, name_low_r};
    if (name_len_r == '0) begin
      match_cfg.active_len = hflm_pkg::LEN_BITS'(1);
    end else if (name_len_r > hflm_pkg::LEN_BITS'(hflm_pkg::NAME_MAX_BYTES)) begin
      match_cfg.active_len = hflm_pkg::LEN_BITS'(hflm_pkg::NAME_MAX_BYTES);
    end else begin
      match_cfg.active_len = name_len_r;
    end
  end

endmodule

>>> rtl/hflm_scan.sv
// ----------------------------------------------------------------------------
// hflm_scan
// Per-beat line scanner: position count, name compare and blank skipping.
// ----------------------------------------------------------------------------
`include "header_field_line_matcher_macros.svh"

module hflm_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat_take,
  input  hflm_pkg::in_beat_t    beat,
  input  hflm_pkg::match_cfg_t  match_cfg,
  output logic                  res_valid,
  output hflm_pkg::out_beat_t   res
);

  logic [hflm_pkg::POS_BITS-1:0] pos_r, pos_nxt;
  logic                          line_start_r, line_start_nxt;
  logic [hflm_pkg::LEN_BITS-1:0] idx_r, idx_nxt;
  logic                          matching_r, matching_nxt;
  logic                          done_r, done_nxt;
  logic                          skip_r, skip_nxt;
  logic [hflm_pkg::POS_BITS-1:0] vstart_r, vstart_nxt;
  logic                          sat_r, sat_nxt;

  logic [7:0]                    folded;
  logic [hflm_pkg::LEN_BITS-1:0] cur_idx;
  logic [hflm_pkg::LEN_BITS-1:0] idx_inc;
  logic                          comparing;
  logic                          is_blank;

  always_comb begin
    pos_nxt        = pos_r;
    line_start_nxt = line_start_r;
    idx_nxt        = idx_r;
    matching_nxt   = matching_r;
    done_nxt       = done_r;
    skip_nxt       = skip_r;
    vstart_nxt     = vstart_r;
    sat_nxt        = sat_r;

    folded = ((beat.text_byte >= hflm_pkg::CHAR_UPPER_A) &&
              (beat.text_byte <= hflm_pkg::CHAR_UPPER_Z)) ?
             beat.text_byte + hflm_pkg::CASE_OFFSET : beat.text_byte;
    is_blank  = (beat.text_byte == hflm_pkg::CHAR_SPACE) ||
                (beat.text_byte == hflm_pkg::CHAR_TAB);
    comparing = matching_r || line_start_r;
    cur_idx   = matching_r ? idx_r : '0;
    idx_inc   = cur_idx + hflm_pkg::LEN_BITS'(1);

    if (beat_take) begin
      if (beat.terminator) begin
        pos_nxt        = '0;
        line_start_nxt = 1'b1;
        idx_nxt        = '0;
        matching_nxt   = 1'b0;
        done_nxt       = 1'b0;
        skip_nxt       = 1'b0;
        vstart_nxt     = '0;
        sat_nxt        = 1'b0;
      end else begin
        if (pos_r == hflm_pkg::POS_MAX) begin
          sat_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + hflm_pkg::POS_BITS'(1);
        end

        if (!done_r) begin
          if (comparing) begin
            if (folded == match_cfg.name[cur_idx[3:0]]) begin
              if (idx_inc >= match_cfg.active_len) begin
                done_nxt     = 1'b1;
                matching_nxt = 1'b0;
                skip_nxt     = 1'b1;
                idx_nxt      = idx_inc;
                vstart_nxt   = pos_nxt;
              end else begin
                matching_nxt = 1'b1;
                idx_nxt      = idx_inc;
              end
            end else begin
              matching_nxt = 1'b0;
              idx_nxt      = '0;
            end
          end
        end else if (skip_r) begin
          if (is_blank) begin
            vstart_nxt = pos_nxt;
          end else begin
            skip_nxt = 1'b0;
          end
        end

        line_start_nxt = (beat.text_byte == hflm_pkg::CHAR_NEWLINE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      line_start_r <= 1'b1;
      idx_r        <= '0;
      matching_r   <= 1'b0;
      done_r       <= 1'b0;
      skip_r       <= 1'b0;
      vstart_r     <= '0;
      sat_r        <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      line_start_r <= line_start_nxt;
      idx_r        <= idx_nxt;
      matching_r   <= matching_nxt;
      done_r       <= done_nxt;
      skip_r       <= skip_nxt;
      vstart_r     <= vstart_nxt;
      sat_r        <= sat_nxt;
    end
  end

  // The answer is formed from the state as it stands before the closing beat.
  assign res_valid          = beat_take && beat.terminator;
  assign res.found          = done_r;
  assign res.value_offset   = done_r ? hflm_pkg::OFFSET_BITS'(vstart_r) : '0;
  assign res.overflow       = sat_r;

  `HFLM_ASSERT_NEXT(a_clear_after_term, beat_take && beat.terminator, (pos_r == '0) && line_start_r && !done_r)
  `HFLM_ASSERT_NOW(a_skip_needs_match, skip_r, done_r && !matching_r)

endmodule

>>> rtl/hflm_result_reg.sv
// ----------------------------------------------------------------------------
// hflm_result_reg
// Output register holding one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module hflm_result_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  hflm_pkg::out_beat_t  res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output hflm_pkg::out_beat_t  out_data
);

  logic                out_valid_r, out_valid_nxt;
  hflm_pkg::out_beat_t out_data_r;

  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/header_field_line_matcher.sv
// ----------------------------------------------------------------------------
// header_field_line_matcher
// Finds the first header line that starts with a configured field name,
// folding upper-case header letters, and reports where its value begins.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Beat
//   in_      input      in_valid / in_stall   in_beat_t  (text_byte, terminator)
//   out_     output     out_valid / out_stall out_beat_t (found, value_offset,
//                                                         overflow)
//   cfg_     input      cfg_wr_en             cfg_index, cfg_wdata
//
// One input beat is taken per cycle unless a terminator is held off; each byte
// updates the scan state in the cycle it is accepted, so the throughput is one
// beat per clock while no terminator waits. A terminator beat yields its result
// on out_ in the cycle after acceptance, through a single output register.
// Byte beats are accepted even while a result waits on a stalled out_; only a
// terminator beat is held off then, since the output register is occupied.
// rst_n is synchronous and active low; it clears the scan state and the
// output valid, and loads the reset register values (name length of one).
// ----------------------------------------------------------------------------
`include "header_field_line_matcher_macros.svh"

module header_field_line_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hflm_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hflm_pkg::out_beat_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [hflm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hflm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  hflm_pkg::match_cfg_t match_cfg;
  hflm_pkg::out_beat_t  res;
  logic                 res_valid;
  logic                 beat_take;

  // The output register is full and will not drain this cycle, so a new
  // result has nowhere to go. Plain bytes produce no result and pass.
  assign in_stall  = out_valid && out_stall && in_data.terminator;
  assign beat_take = in_valid && !in_stall;

  hflm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .match_cfg (match_cfg)
  );

  hflm_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_take (beat_take),
    .beat      (in_data),
    .match_cfg (match_cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  hflm_result_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Every accepted terminator shows up as a result beat in the next cycle.
  `HFLM_ASSERT_NEXT(a_term_gives_result, in_valid && !in_stall && in_data.terminator, out_valid)
  // A held result is never overwritten by a new terminator.
  `HFLM_ASSERT_NOW(a_no_overwrite, out_valid && out_stall && in_valid && in_data.terminator, in_stall)

endmodule

>>> bench/header_field_line_matcher_test.sv
// ----------------------------------------------------------------------------
// Header field line matcher testbench
// Streams header blocks byte by byte through the matcher and checks every
// answer against a scoreboard of expected answers. A short scripted part
// comes first. Random blocks follow, under several field-name settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module header_field_line_matcher_test;
  import hflm_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int NAME_PHASES     = 8;
  localparam int PRESSURE_PHASE  = 3;
  localparam int BEATS_PER_PHASE = 100;
  localparam int MIN_BLOCKS      = 70;
  localparam int HOLD_CYCLES     = 150;

  localparam logic [7:0] CHAR_RETURN = 8'h0D;

  typedef enum {ROW_BYTE, ROW_TERM, ROW_CFG} row_kind_e;

  // One line of the scripted part. A terminator row may carry an answer typed
  // in by hand; otherwise the predictor supplies the expected answer.
  typedef struct {
    row_kind_e               kind;
    logic [7:0]              text_byte;
    logic [CFG_IDX_BITS-1:0] reg_sel;
    logic [CFG_DATA_BITS-1:0] reg_value;
    bit                      has_answer;
    out_beat_t               answer;
  } script_row_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_beat_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_beat_t                out_data;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_NAME_LOW;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  header_field_line_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the name registers and of the scan.
  // --------------------------------------------------------------------------
  logic [63:0]         name_lo;
  logic [63:0]         name_hi;
  logic [LEN_BITS-1:0] name_len_reg;

  logic [POS_BITS-1:0] scan_count;
  bit                  at_line_head;
  logic [4:0]          cmp_index;
  bit                  comparing;
  bit                  name_hit;
  bit                  in_blanks;
  logic [POS_BITS-1:0] value_mark;
  bit                  count_saturated;

  // Answers still owed by the block, oldest first.
  out_beat_t   expected_answers[$];
  script_row_t directed_script[$];

  // The name the stimulus generator builds header lines from.
  logic [7:0] name_text[NAME_SLOTS];
  int         name_span;

  int  errors = 0;
  int  cycle_count = 0;
  int  beats_sent = 0;
  int  blocks_sent = 0;
  int  name_settings = 0;
  int  held_off_cycles = 0;
  int  answers_checked = 0;
  int  answers_found = 0;
  int  answers_overflow = 0;

  // Idling controls. calm switches off the random gaps and stalls; each bump
  // of hold_asks makes the receiver hold its stall until hold_left, loaded from HOLD_CYCLES, runs out.
  bit  calm = 1'b0;
  int  hold_asks = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  run_left = 0;
  bit  stalling = 1'b0;
  out_beat_t oldest;

  function automatic void clear_scan();
    scan_count      = '0;
    at_line_head    = 1'b1;
    cmp_index       = '0;
    comparing       = 1'b0;
    name_hit        = 1'b0;
    in_blanks       = 1'b0;
    value_mark      = '0;
    count_saturated = 1'b0;
  endfunction

  // A length of zero still compares one byte, and anything past the name
  // storage is clipped to it.
  function automatic int active_span();
    int n;
    n = int'(name_len_reg);
    if (n == 0) n = 1;
    if (n > NAME_MAX_BYTES) n = NAME_MAX_BYTES;
    return n;
  endfunction

  // Advances the scan by one accepted beat. A terminator yields the answer
  // for the block and starts a fresh one; a byte yields nothing.
  function automatic void scan_item(input logic term, input logic [7:0] b,
                                    output out_beat_t answer, output bit answered);
    logic [127:0] name_all;
    logic [7:0]   folded;
    logic [7:0]   want;
    answer   = '0;
    answered = 1'b0;
    if (term) begin
      answer.found        = name_hit;
      answer.value_offset = name_hit ? value_mark : '0;
      answer.overflow     = count_saturated;
      answered            = 1'b1;
      clear_scan();
    end else begin
      if (scan_count == POS_MAX) count_saturated = 1'b1;
      else scan_count = scan_count + 1'b1;
      folded   = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
      name_all = {name_hi, name_lo};
      if (!name_hit) begin
        // A new candidate opens only at a line head and only when no other
        // candidate is still being compared.
        if (at_line_head && !comparing) begin
          comparing = 1'b1;
          cmp_index = '0;
        end
        if (comparing) begin
          want = name_all[cmp_index[3:0]*8 +: 8];
          if (folded == want) begin
            cmp_index = cmp_index + 1'b1;
            if (cmp_index >= active_span()) begin
              name_hit   = 1'b1;
              comparing  = 1'b0;
              in_blanks  = 1'b1;
              value_mark = scan_count;
            end
          end else begin
            comparing = 1'b0;
            cmp_index = '0;
          end
        end
      end else if (in_blanks) begin
        // The value start trails each space or tab, so a block that ends in
        // blanks reports its own length.
        if (b == CHAR_SPACE || b == CHAR_TAB) value_mark = scan_count;
        else in_blanks = 1'b0;
      end
      at_line_head = (b == CHAR_NEWLINE);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scripted stimulus rows.
  // --------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    directed_script.push_back('{ROW_BYTE, b, REG_NAME_LOW, '0, 1'b0, '0});
  endfunction

  function automatic void add_text(input string s);
    script_row_t r;
    r = '{ROW_BYTE, 8'h00, REG_NAME_LOW, '0, 1'b0, '0};
    for (int k = 0; k < s.len(); k++) begin
      r.text_byte = s[k];
      directed_script.push_back(r);
    end
  endfunction

  function automatic void add_term(input logic [7:0] b, input bit typed,
                                   input out_beat_t ans);
    directed_script.push_back('{ROW_TERM, b, REG_NAME_LOW, '0, typed, ans});
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] sel,
                                  input logic [CFG_DATA_BITS-1:0] val);
    directed_script.push_back('{ROW_CFG, 8'h00, sel, val, 1'b0, '0});
  endfunction

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------
  // Most gaps are zero or short; a few are long enough to span a whole block.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Offers one beat, holds it until it is taken, then books the prediction.
  // Valid is left high on return so back-to-back beats need no extra edge.
  task automatic send_beat(input logic term, input logic [7:0] b, input bit typed,
                           input out_beat_t typed_answer);
    int        gap;
    out_beat_t predicted;
    bit        answered;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{terminator: term, text_byte: b};
    @(posedge clk);
    while (in_stall) begin
      held_off_cycles++;
      @(posedge clk);
    end
    scan_item(term, b, predicted, answered);
    if (answered) begin
      expected_answers.push_back(typed ? typed_answer : predicted);
      blocks_sent++;
    end
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(1'b0, b, 1'b0, '0);
  endtask

  // The byte of a terminator beat is ignored, so it gets random content.
  task automatic send_end();
    send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Stops offering beats, waits until every owed answer has come out and then
  // lets the scan go quiet.
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write strobe drops for one cycle after each write, so back-to-back
  // writes never drive it twice at the same edge.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] sel,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (sel)
      REG_NAME_LOW:  name_lo = val;
      REG_NAME_HIGH: name_hi = val;
      REG_NAME_LEN:  name_len_reg = val[LEN_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_name(input logic [LEN_BITS-1:0] len_value);
    logic [63:0] lo;
    logic [63:0] hi;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = name_text[k];
      hi[8*k +: 8] = name_text[k+8];
    end
    write_reg(REG_NAME_LOW, lo);
    write_reg(REG_NAME_HIGH, hi);
    write_reg(REG_NAME_LEN, {{(CFG_DATA_BITS-LEN_BITS){1'b0}}, len_value});
    name_span = active_span();
    name_settings++;
  endtask

  // Sends the active name with its lower-case letters randomly raised, which
  // the block must fold back before comparing.
  task automatic send_name_line();
    logic [7:0] c;
    for (int k = 0; k < name_span; k++) begin
      c = name_text[k];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
      send_byte(c);
    end
  endtask

  // One header block of up to three lines: full name lines with blanks and a
  // value, lines that break off partway through the name, plain text and raw
  // noise. The last line may stop in the blanks or inside the name.
  task automatic send_header_block();
    int lines;
    int pick;
    int n;
    bit last;
    lines = $urandom_range(0, 3);
    for (int i = 0; i < lines; i++) begin
      last = (i == lines - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_name_line();
        n = $urandom_range(0, 3);
        repeat (n) send_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        if (!(last && $urandom_range(0, 2) == 0))
          repeat ($urandom_range(1, 4)) send_byte(printable_char());
      end else if (pick < 60) begin
        n = $urandom_range(0, name_span - 1);
        for (int k = 0; k < n; k++) send_byte(name_text[k]);
        if (!(last && $urandom_range(0, 1) == 0)) begin
          send_byte(8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 3)) send_byte(printable_char());
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_byte(printable_char());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      if (!last || $urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 3) == 0) send_byte(CHAR_RETURN);
        send_byte(CHAR_NEWLINE);
      end
    end
    send_end();
  endtask

  // --------------------------------------------------------------------------
  // Output side: checks each accepted answer and then picks the next stall.
  // Runs of no stall alternate with short stalls and the odd long one; a
  // requested hold keeps the stall up long enough for the output register
  // to fill and push back on terminator beats.
  // --------------------------------------------------------------------------
  function automatic void n_pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      stalling = 1'b0;
      run_left = $urandom_range(1, 8);
    end else if (r < 93) begin
      stalling = 1'b1;
      run_left = $urandom_range(1, 3);
    end else begin
      stalling = 1'b1;
      run_left = $urandom_range(10, 40);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_checked++;
        if (out_data.found) answers_found++;
        if (out_data.overflow) answers_overflow++;
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: answer with none expected, got %p", $time, out_data);
        end else begin
          oldest = expected_answers.pop_front();
          if (out_data.found !== oldest.found) begin
            errors++;
            $display("%0t: found expected %0d, got %0d", $time, oldest.found,
                     out_data.found);
          end
          if (out_data.value_offset !== oldest.value_offset) begin
            errors++;
            $display("%0t: value_offset expected %0d, got %0d", $time,
                     oldest.value_offset, out_data.value_offset);
          end
          if (out_data.overflow !== oldest.overflow) begin
            errors++;
            $display("%0t: overflow expected %0d, got %0d", $time, oldest.overflow,
                     out_data.overflow);
          end
        end
      end
      if (holds_served != hold_asks) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          n_pick_stall();
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  // A hung handshake or an answer that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d answers still owed", $time,
               cycle_count, expected_answers.size());
      $display("header_field_line_matcher test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int                  phase_start;
    logic [LEN_BITS-1:0] len_value;
    int                  r;

    name_lo      = '0;
    name_hi      = '0;
    name_len_reg = LEN_BITS'(1);
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset the name is a single zero byte. An empty block finds
    // nothing; a zero byte followed by blanks matches, and the block ends in
    // the blanks so the offset is the block length.
    add_term(8'h00, 1'b1, '{found: 1'b0, value_offset: 16'd0, overflow: 1'b0});
    add_byte(8'h00);
    add_text(" \t");
    add_term(8'h00, 1'b1, '{found: 1'b1, value_offset: 16'd3, overflow: 1'b0});
    // Name "host": an all upper-case line folds onto it, the trailing tab
    // moves the value start to the end of the block.
    add_cfg(REG_NAME_LOW, 64'h0000_0000_7473_6f68);
    add_cfg(REG_NAME_LEN, 64'd4);
    add_text("HOST\t");
    add_term(8'hFF, 1'b1, '{found: 1'b1, value_offset: 16'd5, overflow: 1'b0});
    // The match on the second line is left to the predictor.
    add_text("x\nhost:");
    add_term(8'h5A, 1'b0, '0);
    // A partial name broken by an all-ones byte finds nothing.
    add_text({"hos", 8'hFF});
    add_term(8'hA5, 1'b1, '{found: 1'b0, value_offset: 16'd0, overflow: 1'b0});

    foreach (directed_script[i]) begin
      case (directed_script[i].kind)
        ROW_CFG: begin
          settle_idle();
          write_reg(directed_script[i].reg_sel, directed_script[i].reg_value);
        end
        ROW_BYTE: send_byte(directed_script[i].text_byte);
        default: send_beat(1'b1, directed_script[i].text_byte,
                           directed_script[i].has_answer, directed_script[i].answer);
      endcase
    end

    // Random blocks under a series of names. The length register sweeps zero,
    // the maximum, values past the maximum, one, and random values between.
    for (int phase = 0; phase < NAME_PHASES; phase++) begin
      settle_idle();
      case (phase)
        0:       len_value = LEN_BITS'(0);
        1:       len_value = LEN_BITS'(NAME_MAX_BYTES);
        2:       len_value = {LEN_BITS{1'b1}};
        3:       len_value = LEN_BITS'(1);
        4:       len_value = LEN_BITS'(NAME_MAX_BYTES + 1);
        default: len_value = LEN_BITS'($urandom_range(2, NAME_MAX_BYTES - 1));
      endcase
      // Mostly lower-case letters and dashes, now and then any byte, a
      // newline or an upper-case letter that can never match a folded byte.
      for (int k = 0; k < NAME_SLOTS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80)      name_text[k] = 8'("a" + $urandom_range(0, 25));
        else if (r < 88) name_text[k] = "-";
        else if (r < 94) name_text[k] = 8'($urandom_range(0, 255));
        else if (r < 97) name_text[k] = CHAR_NEWLINE;
        else             name_text[k] = 8'("A" + $urandom_range(0, 25));
      end
      write_name(len_value);

      // The receiver sits on its stall while short blocks keep coming, so
      // the output register fills and terminator beats are pushed back.
      if (phase == PRESSURE_PHASE) begin
        calm      <= 1'b1;
        hold_asks <= hold_asks + 1;
        repeat (30) begin
          if ($urandom_range(0, 1) == 1) send_byte(printable_char());
          send_end();
        end
        calm <= 1'b0;
      end

      phase_start = beats_sent;
      while (beats_sent - phase_start < BEATS_PER_PHASE ||
             (phase == NAME_PHASES - 1 && blocks_sent < MIN_BLOCKS))
        send_header_block();
    end

    settle_idle();
    $display("Sent %0d beats in %0d blocks under %0d names; input held off %0d cycles.",
             beats_sent, blocks_sent, name_settings, held_off_cycles);
    $display("Checked %0d answers: %0d with a match, %0d saturated.",
             answers_checked, answers_found, answers_overflow);
    if (errors == 0) begin
      $display("header_field_line_matcher test passed");
    end else begin
      $display("header_field_line_matcher test failed");
    end
    $finish;
  end

endmodule

>>> header_field_line_matcher.f
+incdir+rtl
rtl/hflm_pkg.sv
rtl/hflm_cfg_regs.sv
rtl/hflm_scan.sv
rtl/hflm_result_reg.sv
rtl/header_field_line_matcher.sv
bench/header_field_line_matcher_test.sv
